// File: rtl/irfd_pkg.sv
// irfd_pkg: shared types and constants for the IR remote frame decoder.
// No dependencies; imported by every module in rtl/.

package irfd_pkg;

    localparam int CNT_W        = 19;
    localparam int IDX_W        = 6;
    localparam int CMD_W        = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};
    localparam logic [IDX_W-1:0] EDGE_LIMIT  = 6'd50;
    localparam logic [IDX_W-1:0] BIT_FIRST   = 6'd17;
    localparam logic [IDX_W-1:0] BIT_LAST    = 6'd24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX   = 3'd4;

    localparam logic [CNT_W-1:0] TIMEOUT_RST   = 19'd500000;
    localparam logic [CNT_W-1:0] START_MIN_RST = 19'd10000;
    localparam logic [CNT_W-1:0] START_MAX_RST = 19'd14000;
    localparam logic [CNT_W-1:0] ONE_MIN_RST   = 19'd2000;
    localparam logic [CNT_W-1:0] ONE_MAX_RST   = 19'd2300;

    // command codes that drive the pins
    localparam logic [CMD_W-1:0] CMD_PIN1_SET = 8'd69;
    localparam logic [CMD_W-1:0] CMD_PIN1_CLR = 8'd70;
    localparam logic [CMD_W-1:0] CMD_PIN2_SET = 8'd71;
    localparam logic [CMD_W-1:0] CMD_PIN2_CLR = 8'd68;
    localparam logic [CMD_W-1:0] CMD_PIN3_SET = 8'd67;
    localparam logic [CMD_W-1:0] CMD_PIN3_CLR = 8'd66;

    typedef struct packed {
        logic [CNT_W-1:0] timeout_ticks;
        logic [CNT_W-1:0] start_min;
        logic [CNT_W-1:0] start_max;
        logic [CNT_W-1:0] one_min;
        logic [CNT_W-1:0] one_max;
    } cfg_t;

    // classified sample: only whether a falling edge occurred matters downstream
    typedef struct packed {
        logic falling;
    } sample_t;

    typedef struct packed {
        logic    valid;
        sample_t item;
    } q_out_t;

endpackage

// File: rtl/ir_remote_frame_decoder_unit.sv
// ir_remote_frame_decoder_unit: top level of the IR remote frame decoder.
// Depends on irfd_pkg, irfd_front, irfd_queue, irfd_back.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------------
//  in       | in_valid / in_stall    | ir_level
//  out      | out_valid / out_stall  | pin_one pin_two pin_three command_code
//           |                        | frame_done frame_valid
//  cfg      | cfg_valid / cfg_ready  | cfg_index cfg_data
//
// One sample per cycle sustained while out_stall is low; a sample's result is registered in
// a queue entry, then in the back unit's result register.
// The back unit's per-sample timer update and window compares feed that result register.
// A two-entry queue decouples front and back, so in_stall rises only when out_stall
// has held the back unit long enough to fill it. cfg_ready is always high.
// Reset is asynchronous; all control state and the config registers take reset values.

module ir_remote_frame_decoder_unit
    import irfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 ir_level,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 pin_one,
    output logic                 pin_two,
    output logic                 pin_three,
    output logic [CMD_W-1:0]     command_code,
    output logic                 frame_done,
    output logic                 frame_valid,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data
);

    cfg_t    cfg_reg;
    sample_t front_item;
    q_out_t  head;
    logic    q_full;
    logic    accept;
    logic    pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
            cfg_reg.start_min     <= START_MIN_RST;
            cfg_reg.start_max     <= START_MAX_RST;
            cfg_reg.one_min       <= ONE_MIN_RST;
            cfg_reg.one_max       <= ONE_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT:   cfg_reg.timeout_ticks <= cfg_data;
                CFG_START_MIN: cfg_reg.start_min     <= cfg_data;
                CFG_START_MAX: cfg_reg.start_max     <= cfg_data;
                CFG_ONE_MIN:   cfg_reg.one_min       <= cfg_data;
                CFG_ONE_MAX:   cfg_reg.one_max       <= cfg_data;
                default:       cfg_reg               <= cfg_reg;
            endcase
        end
    end

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    irfd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .ir_level (ir_level),
        .item     (front_item)
    );

    irfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .pop       (pop),
        .full      (q_full),
        .head      (head)
    );

    irfd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pin_one      (pin_one),
        .pin_two      (pin_two),
        .pin_three    (pin_three),
        .command_code (command_code),
        .frame_done   (frame_done),
        .frame_valid  (frame_valid)
    );

    // a valid frame is only reported together with its judgment
    a_valid_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_valid |-> frame_done)
        else $error("frame_valid without frame_done");

    // a rejected frame clears the command byte
    a_reject_clears_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done && !frame_valid |-> command_code == '0)
        else $error("rejected frame left a nonzero command");

    // the back unit never pops an empty queue
    a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

    // a result shows up the cycle after a pop
    a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid)
        else $error("pop without a following result");

endmodule

// File: rtl/irfd_front.sv
// irfd_front: accepts line samples and classifies each as falling edge or not.
// Depends on irfd_pkg.

module irfd_front
    import irfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  logic    ir_level,
    output sample_t item
);

    logic prev_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b1;
        end
        else if (accept)
        begin
            prev_level_reg <= ir_level;
        end
    end

    assign item.falling = prev_level_reg & ~ir_level;

endmodule

// File: rtl/irfd_queue.sv
// irfd_queue: two-entry FIFO of classified samples between front and back.
// Depends on irfd_pkg.

module irfd_queue
    import irfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  sample_t push_item,
    input  logic    pop,
    output logic    full,
    output q_out_t  head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    sample_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_QW-1:0]  count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_QW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_QW'(1);
            end
        end
    end

    assign full       = (count_reg == CNT_QW'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

endmodule

// File: rtl/irfd_back.sv
// irfd_back: interval timer, bit capture, frame judgment and pin control.
// Holds the result register. Depends on irfd_pkg.

module irfd_back
    import irfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  q_out_t           head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             pin_one,
    output logic             pin_two,
    output logic             pin_three,
    output logic [CMD_W-1:0] command_code,
    output logic             frame_done,
    output logic             frame_valid
);

    logic             armed_reg, armed_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_inc;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] start_reg, start_next;
    logic [CMD_W-1:0] bits_reg, bits_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [2:0]       pins_reg, pins_next;
    logic             done_reg, done_next;
    logic             fvalid_reg, fvalid_next;
    logic             out_valid_reg;
    logic             is_one, start_ok;
    logic [2:0]       bit_sel;
    logic [IDX_W-1:0] bit_off;

    assign pop = head.valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        cnt_inc     = (armed_reg && cnt_reg != CNT_MAX) ? cnt_reg + CNT_W'(1) : cnt_reg;
        armed_next  = armed_reg;
        cnt_next    = cnt_inc;
        idx_next    = idx_reg;
        start_next  = start_reg;
        bits_next   = bits_reg;
        cmd_next    = cmd_reg;
        pins_next   = pins_reg;
        done_next   = 1'b0;
        fvalid_next = 1'b0;
        is_one      = (cnt_inc >= cfg.one_min) && (cnt_inc <= cfg.one_max);
        start_ok    = (start_reg >= cfg.start_min) && (start_reg <= cfg.start_max);
        bit_off     = idx_reg - BIT_FIRST;
        bit_sel     = bit_off[2:0];

        if (head.item.falling)
        begin
            if (!armed_reg)
            begin
                armed_next = 1'b1;
                cnt_next   = '0;
            end
            else
            begin
                if (idx_reg == '0)
                begin
                    start_next = cnt_inc;
                end
                else if (idx_reg >= BIT_FIRST && idx_reg <= BIT_LAST)
                begin
                    bits_next[bit_sel] = is_one;
                end
                if (idx_reg < EDGE_LIMIT)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
                cnt_next = '0;
            end
        end
        else if (armed_reg && cnt_inc >= cfg.timeout_ticks)
        begin
            done_next = 1'b1;
            if (start_ok)
            begin
                fvalid_next = 1'b1;
                cmd_next    = bits_reg;
                unique case (bits_reg)
                    CMD_PIN1_SET: pins_next[0] = 1'b1;
                    CMD_PIN1_CLR: pins_next[0] = 1'b0;
                    CMD_PIN2_SET: pins_next[1] = 1'b1;
                    CMD_PIN2_CLR: pins_next[1] = 1'b0;
                    CMD_PIN3_SET: pins_next[2] = 1'b1;
                    CMD_PIN3_CLR: pins_next[2] = 1'b0;
                    default:      pins_next    = pins_reg;
                endcase
            end
            else
            begin
                cmd_next = '0;
            end
            armed_next = 1'b0;
            start_next = '0;
            idx_next   = '0;
            cnt_next   = '0;
        end
    end

    // state only advances on pop, so the result fields hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            start_reg     <= '0;
            bits_reg      <= '0;
            cmd_reg       <= '0;
            pins_reg      <= '0;
            done_reg      <= 1'b0;
            fvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                armed_reg  <= armed_next;
                cnt_reg    <= cnt_next;
                idx_reg    <= idx_next;
                start_reg  <= start_next;
                bits_reg   <= bits_next;
                cmd_reg    <= cmd_next;
                pins_reg   <= pins_next;
                done_reg   <= done_next;
                fvalid_reg <= fvalid_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign pin_one      = pins_reg[0];
    assign pin_two      = pins_reg[1];
    assign pin_three    = pins_reg[2];
    assign command_code = cmd_reg;
    assign frame_done   = done_reg;
    assign frame_valid  = fvalid_reg;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for ir_remote_frame_decoder_unit (bench/testbench.sv).
// Depends on irfd_pkg and the RTL top; predicts pins and command byte per line sample.

module testbench;

    import irfd_pkg::*;

    localparam int REG_MAX     = 500000;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 60;

    typedef struct packed {
        logic             pin_one;
        logic             pin_two;
        logic             pin_three;
        logic [CMD_W-1:0] command_code;
        logic             frame_done;
        logic             frame_valid;
    } decoder_status_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 ir_level = 1'b1;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 pin_one;
    logic                 pin_two;
    logic                 pin_three;
    logic [CMD_W-1:0]     command_code;
    logic                 frame_done;
    logic                 frame_valid;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_TIMEOUT;
    logic [CNT_W-1:0]     cfg_data = '0;

    // decoder state as predicted from the accepted samples
    logic                 armed = 1'b0;
    logic                 last_level = 1'b1;
    logic [CNT_W-1:0]     tick_count = '0;
    logic [IDX_W-1:0]     edge_count = '0;
    logic [CNT_W-1:0]     lead_interval = '0;
    logic [CMD_W-1:0]     cmd_bits = '0;
    logic [CMD_W-1:0]     cmd_latched = '0;
    logic [2:0]           pin_state = '0;

    logic [CNT_W-1:0]     cfg_timeout = TIMEOUT_RST;
    logic [CNT_W-1:0]     cfg_start_lo = START_MIN_RST;
    logic [CNT_W-1:0]     cfg_start_hi = START_MAX_RST;
    logic [CNT_W-1:0]     cfg_one_lo = ONE_MIN_RST;
    logic [CNT_W-1:0]     cfg_one_hi = ONE_MAX_RST;

    decoder_status_t      status_fifo[$];
    int                   train[$];

    logic [CMD_W-1:0]     pin_codes[6] = '{CMD_PIN1_SET, CMD_PIN2_SET, CMD_PIN3_SET,
                                           CMD_PIN1_CLR, CMD_PIN2_CLR, CMD_PIN3_CLR};

    int                   send_gap_pct = 0;
    int                   stall_pct = 0;
    int                   mismatch_count = 0;
    int                   samples_sent = 0;
    int                   frames_judged = 0;
    int                   frames_valid = 0;
    int                   cycle_count = 0;

    ir_remote_frame_decoder_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .ir_level     (ir_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pin_one      (pin_one),
        .pin_two      (pin_two),
        .pin_three    (pin_three),
        .command_code (command_code),
        .frame_done   (frame_done),
        .frame_valid  (frame_valid),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: watchdog: cycle limit reached, %0d results outstanding",
                     $time, status_fifo.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    // advance the predicted decoder by one line sample
    function automatic void step_decoder(input logic lvl);
        decoder_status_t s;
        logic            fall;
        fall = last_level && !lvl;
        last_level = lvl;
        s.frame_done = 1'b0;
        s.frame_valid = 1'b0;
        if (armed && tick_count != CNT_MAX)
            tick_count++;
        if (fall)
        begin
            if (!armed)
            begin
                armed = 1'b1;
                tick_count = '0;
            end
            else
            begin
                if (edge_count == 0)
                    lead_interval = tick_count;
                else if (edge_count >= BIT_FIRST && edge_count <= BIT_LAST)
                    cmd_bits[edge_count - BIT_FIRST] =
                        (tick_count >= cfg_one_lo && tick_count <= cfg_one_hi);
                if (edge_count < EDGE_LIMIT)
                    edge_count++;
                tick_count = '0;
            end
        end
        else if (armed && tick_count >= cfg_timeout)
        begin
            s.frame_done = 1'b1;
            if (lead_interval >= cfg_start_lo && lead_interval <= cfg_start_hi)
            begin
                s.frame_valid = 1'b1;
                cmd_latched = cmd_bits;
                case (cmd_latched)
                    CMD_PIN1_SET: pin_state[0] = 1'b1;
                    CMD_PIN1_CLR: pin_state[0] = 1'b0;
                    CMD_PIN2_SET: pin_state[1] = 1'b1;
                    CMD_PIN2_CLR: pin_state[1] = 1'b0;
                    CMD_PIN3_SET: pin_state[2] = 1'b1;
                    CMD_PIN3_CLR: pin_state[2] = 1'b0;
                    default: ;
                endcase
            end
            else
                cmd_latched = '0;
            armed = 1'b0;
            lead_interval = '0;
            edge_count = '0;
            tick_count = '0;
        end
        s.pin_one = pin_state[0];
        s.pin_two = pin_state[1];
        s.pin_three = pin_state[2];
        s.command_code = cmd_latched;
        status_fifo.push_back(s);
    endfunction

    function automatic void check_field(input string field_name, input logic [CMD_W-1:0] want,
                                        input logic [CMD_W-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field_name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        decoder_status_t want;
        if (out_valid && !out_stall)
        begin
            if (frame_done)
                frames_judged++;
            if (frame_valid)
                frames_valid++;
            if (status_fifo.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unpredicted result: expected none, got command_code %0d",
                         $time, command_code);
            end
            else
            begin
                want = status_fifo.pop_front();
                check_field("pin_one", want.pin_one, pin_one);
                check_field("pin_two", want.pin_two, pin_two);
                check_field("pin_three", want.pin_three, pin_three);
                check_field("command_code", want.command_code, command_code);
                check_field("frame_done", want.frame_done, frame_done);
                check_field("frame_valid", want.frame_valid, frame_valid);
            end
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // one line sample per transaction; called in the time step of a rising edge
    task automatic send_level(input logic lvl);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ir_level <= lvl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        samples_sent++;
        step_decoder(lvl);
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (status_fifo.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_TIMEOUT:   cfg_timeout = val;
            CFG_START_MIN: cfg_start_lo = val;
            CFG_START_MAX: cfg_start_hi = val;
            CFG_ONE_MIN:   cfg_one_lo = val;
            CFG_ONE_MAX:   cfg_one_hi = val;
            default: ;
        endcase
    endtask

    task automatic set_timing(input int timeout, input int start_lo, input int start_hi,
                              input int one_lo, input int one_hi);
        wait_quiet();
        write_reg(CFG_TIMEOUT, CNT_W'(timeout));
        write_reg(CFG_START_MIN, CNT_W'(start_lo));
        write_reg(CFG_START_MAX, CNT_W'(start_hi));
        write_reg(CFG_ONE_MIN, CNT_W'(one_lo));
        write_reg(CFG_ONE_MAX, CNT_W'(one_hi));
    endtask

    // interval list for one frame: lead, address filler, then the command bits
    function automatic void plan_frame(input int lead, input int count,
                                       input logic [CMD_W-1:0] code);
        int i;
        int lo;
        int hi;
        train.delete();
        lo = (cfg_one_lo < 2) ? 2 : int'(cfg_one_lo);
        hi = (cfg_one_hi > lo + 3) ? lo + 3 : int'(cfg_one_hi);
        for (i = 0; i < count; i++)
        begin
            if (i == 0)
                train.push_back(lead);
            else if (i >= BIT_FIRST && i <= BIT_LAST)
            begin
                if (code[i - BIT_FIRST])
                    train.push_back($urandom_range(hi, lo));
                else if (cfg_one_lo > 2 && $urandom_range(0, 1) == 1)
                    train.push_back($urandom_range(2, cfg_one_lo - 1));
                else
                    train.push_back($urandom_range(cfg_one_hi + 1, cfg_one_hi + 3));
            end
            else
                train.push_back($urandom_range(2, 3));
        end
    endfunction

    // arming edge, then each interval as low mark plus high space ending in a falling edge
    task automatic send_train(input int tail);
        int i;
        int k;
        int mark;
        send_level(1'b1);
        send_level(1'b0);
        for (i = 0; i < train.size(); i++)
        begin
            mark = $urandom_range(0, train[i] - 2);
            for (k = 1; k < train[i]; k++)
                send_level(k <= mark ? 1'b0 : 1'b1);
            send_level(1'b0);
        end
        repeat (tail)
            send_level(1'b1);
    endtask

    task automatic test_after_reset();
        // reset windows: a start interval of 2 is far below the start window
        send_level(1'b1);
        send_level(1'b0);
        send_level(1'b1);
        send_level(1'b0);
        send_level(1'b1);
        send_level(1'b1);
        wait_quiet();
        write_reg(CFG_TIMEOUT, 19'd12);
        repeat (cfg_timeout)
            send_level(1'b1);
    endtask

    task automatic test_pin_codes();
        int i;
        set_timing(12, 6, 8, 4, 5);
        for (i = 0; i < 6; i++)
        begin
            plan_frame(7, 25, pin_codes[i]);
            send_train(cfg_timeout);
        end
        plan_frame(7, 25, 8'h00);
        send_train(cfg_timeout);
        plan_frame(7, 25, 8'hFF);
        send_train(cfg_timeout);
    endtask

    task automatic test_start_window();
        plan_frame(cfg_start_lo, 25, CMD_PIN2_SET);
        send_train(cfg_timeout);
        plan_frame(cfg_start_hi, 25, CMD_PIN1_SET);
        send_train(cfg_timeout);
        plan_frame(cfg_start_lo - 1, 25, CMD_PIN1_CLR);
        send_train(cfg_timeout);
        plan_frame(cfg_start_hi + 1, 25, CMD_PIN2_CLR);
        send_train(cfg_timeout);
        // bit intervals on and just outside both ends of the one window
        plan_frame(7, 25, CMD_PIN3_SET);
        train[17] = cfg_one_lo;
        train[18] = cfg_one_hi;
        train[19] = cfg_one_lo - 1;
        train[20] = cfg_one_hi + 1;
        send_train(cfg_timeout);
    endtask

    task automatic test_timeout_edge();
        // edge on the timeout tick wins and the frame goes on
        plan_frame(7, 25, CMD_PIN1_SET);
        train[5] = cfg_timeout;
        send_train(cfg_timeout);
        // one tick longer: judged mid-frame, the rest re-arms as a new frame
        plan_frame(7, 25, CMD_PIN1_CLR);
        train[10] = cfg_timeout + 1;
        send_train(cfg_timeout);
    endtask

    task automatic test_edge_saturation();
        plan_frame(7, 25, CMD_PIN2_CLR);
        repeat (35)
            train.push_back($urandom_range(2, 3));
        send_train(cfg_timeout);
    endtask

    task automatic test_stale_bits();
        plan_frame(7, 25, CMD_PIN1_SET);
        send_train(cfg_timeout);
        // only bits 0..2 arrive; upper bits of the previous code remain
        plan_frame(7, 20, 8'h06);
        send_train(cfg_timeout);
    endtask

    task automatic test_register_extremes();
        int k;
        // shortest timeout and an empty frame judged against a zero-width start window
        set_timing(1, 0, 0, 2, 3);
        send_level(1'b1);
        send_level(1'b0);
        send_level(1'b1);
        send_level(1'b1);
        set_timing(REG_MAX, 0, 19'h3FFFF, 0, REG_MAX);
        plan_frame(5, 25, 8'hFF);
        send_train(0);
        // frame still open: a short timeout closes it
        wait_quiet();
        write_reg(CFG_TIMEOUT, 19'd20);
        repeat (cfg_timeout)
            send_level(1'b1);
        wait_quiet();
        for (k = int'(CFG_ONE_MAX) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), CNT_W'($urandom_range(0, REG_MAX)));
    endtask

    task automatic test_random_traffic();
        int phase;
        int kind;
        int first;
        int tmo;
        int slo;
        int shi;
        int olo;
        int ohi;
        int lead;
        logic paused;
        logic [CMD_W-1:0] code;
        int gap_by_phase[4] = '{0, 48, 0, 10};
        int stall_by_phase[4] = '{0, 0, 48, 10};
        for (phase = 0; phase < 4; phase++)
        begin
            olo = $urandom_range(2, 6);
            ohi = olo + $urandom_range(0, 3);
            tmo = ohi + 3 + $urandom_range(0, 6);
            slo = $urandom_range(2, tmo);
            shi = slo + $urandom_range(0, 3);
            set_timing(tmo, slo, shi, olo, ohi);
            send_gap_pct = gap_by_phase[phase];
            stall_pct = stall_by_phase[phase];
            first = samples_sent;
            paused = 1'b0;
            while (samples_sent - first < PHASE_ITEMS)
            begin
                if (!paused && samples_sent - first >= PHASE_ITEMS / 2)
                begin
                    wait_quiet();
                    paused = 1'b1;
                end
                kind = $urandom_range(0, 99);
                if ($urandom_range(0, 99) < 85)
                    lead = $urandom_range(slo, shi);
                else
                    lead = $urandom_range(2, tmo);
                if ($urandom_range(0, 99) < 60)
                    code = pin_codes[$urandom_range(0, 5)];
                else
                    code = CMD_W'($urandom_range(0, 255));
                if (kind < 70)
                    plan_frame(lead, 25, code);
                else if (kind < 85)
                    plan_frame(lead, $urandom_range(0, 30), code);
                else if (kind < 90)
                begin
                    plan_frame(lead, 25, code);
                    repeat ($urandom_range(26, 40))
                        train.push_back($urandom_range(2, 4));
                end
                else
                begin
                    // noise burst on the line
                    train.delete();
                    repeat ($urandom_range(5, 30))
                        send_level(1'($urandom_range(0, 1)));
                end
                if (train.size() != 0 || kind < 90)
                    send_train(cfg_timeout + $urandom_range(0, 3));
                else
                    repeat (cfg_timeout + $urandom_range(0, 3))
                        send_level(1'b1);
            end
        end
    endtask

    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        test_after_reset();
        test_pin_codes();
        test_start_window();
        test_timeout_edge();
        test_edge_saturation();
        test_stale_bits();
        test_register_extremes();
        test_random_traffic();
        in_valid <= 1'b0;
        @(posedge clk);
        while (status_fifo.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        $display("summary: %0d line samples, %0d frames judged, %0d with a valid start",
                 samples_sent, frames_judged, frames_valid);
        $display("summary: pin codes, window bounds, timeout-tick edges, edge saturation, "
                 , "register extremes, four idle/stall profiles");
        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
